FILE: rtl/pim_pkg.sv
// Shared types, constants and helpers for the photon interval outlier merger.
package pim_pkg;

   localparam int PIM_TOTAL_TICK_BITS = 44;
   localparam int CSR_INDEX_W         = 2;
   localparam int CSR_DATA_W          = 16;
   localparam int PERIOD_W            = 16;
   localparam int STAMP_W             = 60;

   localparam logic [15:0] SAT_LIMIT = 16'd65533;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_SEL  = 2'd1;

   localparam logic [1:0] CLK_6500PS  = 2'd0;
   localparam logic [1:0] CLK_10000PS = 2'd1;
   localparam logic [1:0] CLK_19920PS = 2'd2;
   localparam logic [1:0] CLK_49800PS = 2'd3;

   typedef struct packed {
      logic [15:0] sample_ticks;
      logic        first_of_record;
      logic        last_of_record;
   } pim_req_type;

   typedef struct packed {
      logic               interval_valid;
      logic [31:0]        merged_interval;
      logic [STAMP_W-1:0] timestamp_ps;
      logic [31:0]        outlier_count;
      logic [31:0]        saturated_count;
      logic [31:0]        kept_count;
      logic               end_of_record;
   } pim_rsp_type;

   // tick period in picoseconds
   function automatic logic [PERIOD_W-1:0] tick_period(input logic [1:0] sel);
      logic [PERIOD_W-1:0] p;
      case (sel)
         CLK_6500PS:  p = 16'd6500;
         CLK_10000PS: p = 16'd10000;
         CLK_19920PS: p = 16'd19920;
         CLK_49800PS: p = 16'd49800;
         default:     p = 16'd6500;
      endcase
      return p;
   endfunction

   function automatic logic [31:0] sat_inc32(input logic [31:0] x);
      return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
   endfunction

endpackage

FILE: rtl/pim_stamp.sv
// Timestamp stage: kept ticks times tick period, clamped to 60 bits.
module pim_stamp import pim_pkg::*; #(
   parameter int TOTAL_TICK_BITS = PIM_TOTAL_TICK_BITS
) (
   input  logic [TOTAL_TICK_BITS-1:0] total_ticks,
   input  logic [PERIOD_W-1:0]        period_ps,
   output logic [STAMP_W-1:0]         stamp_ps
);

   localparam int PROD_W = TOTAL_TICK_BITS + PERIOD_W;

   logic [PROD_W-1:0] product;
   logic [63:0]       product_wide;

   assign product      = PROD_W'(total_ticks) * PROD_W'(period_ps);
   assign product_wide = 64'(product);
   assign stamp_ps     = (product_wide[63:STAMP_W] != '0) ? '1 : product_wide[STAMP_W-1:0];

endmodule

FILE: rtl/photon_interval_outlier_merger.sv
// Top level of the photon interval outlier merger.
//
//   port group | dir | flow control      | word
//   req_       | in  | valid / stall     | pim_req_type: sample and record marks
//   rsp_       | out | valid / stall     | pim_rsp_type: interval, timestamp, counts
//   csr_       | in  | valid / ready     | index + 16-bit data (ready always high)
//
// One word per cycle while rsp_stall is low; each request gives one response once
// accepted. The record state (pending sum, ticks, counters) updates in the accept
// cycle; the period multiply sits in the second stage ahead of the response register.
// Reset clears configuration, record state and both stage valids.
// req_stall rises only when both stages hold words and rsp_stall is high.
module photon_interval_outlier_merger import pim_pkg::*; #(
   parameter int TOTAL_TICK_BITS = PIM_TOTAL_TICK_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pim_req_type            req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pim_rsp_type            rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int TW = TOTAL_TICK_BITS;

   logic [15:0]   threshold_ff;
   logic [1:0]    clock_sel_ff;

   logic [31:0]   pending_ff, pending_in;
   logic [TW-1:0] total_ff, total_in;
   logic [31:0]   outliers_ff, outliers_in;
   logic [31:0]   sats_ff, sats_in;
   logic [31:0]   kept_ff, kept_in;

   logic          mid_valid_ff;
   logic          mid_kept_ff;
   logic [31:0]   mid_merged_ff;
   logic [TW-1:0] mid_total_ff;
   logic [PERIOD_W-1:0] mid_period_ff;
   logic [31:0]   mid_outliers_ff;
   logic [31:0]   mid_sats_ff;
   logic [31:0]   mid_kept_count_ff;
   logic          mid_last_ff;

   logic          rsp_valid_ff;
   pim_rsp_type   rsp_data_ff, rsp_data_in;

   logic          out_free, mid_free, req_accept;
   logic          is_outlier, is_sat;
   logic [31:0]   pend_base, outl_base, sats_base, kept_base;
   logic [TW-1:0] total_base;
   logic [32:0]   add_sum;
   logic [31:0]   add_sat;
   logic [TW:0]   total_sum;
   logic [TW-1:0] total_sat;
   logic [STAMP_W-1:0] stamp;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign mid_free   = !mid_valid_ff || out_free;
   assign req_stall  = !mid_free;
   assign req_accept = req_valid && mid_free;
   assign csr_ready  = 1'b1;

   // record state update
   always_comb begin
      pend_base  = req_data.first_of_record ? '0 : pending_ff;
      total_base = req_data.first_of_record ? '0 : total_ff;
      outl_base  = req_data.first_of_record ? '0 : outliers_ff;
      sats_base  = req_data.first_of_record ? '0 : sats_ff;
      kept_base  = req_data.first_of_record ? '0 : kept_ff;

      is_outlier = req_data.sample_ticks < threshold_ff;
      is_sat     = req_data.sample_ticks > SAT_LIMIT;

      add_sum = {1'b0, pend_base} + 33'(req_data.sample_ticks);
      add_sat = add_sum[32] ? '1 : add_sum[31:0];

      total_sum = {1'b0, total_base} + (TW+1)'(add_sat);
      total_sat = total_sum[TW] ? '1 : total_sum[TW-1:0];

      pending_in  = (is_outlier && !req_data.last_of_record) ? add_sat : '0;
      total_in    = is_outlier ? total_base : total_sat;
      outliers_in = is_outlier ? sat_inc32(outl_base) : outl_base;
      sats_in     = is_sat ? sat_inc32(sats_base) : sats_base;
      kept_in     = is_outlier ? kept_base : sat_inc32(kept_base);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         clock_sel_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_data;
            CSR_CLOCK_SEL: clock_sel_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         total_ff    <= '0;
         outliers_ff <= '0;
         sats_ff     <= '0;
         kept_ff     <= '0;
      end else if (req_accept) begin
         pending_ff  <= pending_in;
         total_ff    <= total_in;
         outliers_ff <= outliers_in;
         sats_ff     <= sats_in;
         kept_ff     <= kept_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (mid_free) begin
         mid_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mid_kept_ff       <= !is_outlier;
         mid_merged_ff     <= is_outlier ? '0 : add_sat;
         mid_total_ff      <= total_in;
         mid_period_ff     <= tick_period(clock_sel_ff);
         mid_outliers_ff   <= outliers_in;
         mid_sats_ff       <= sats_in;
         mid_kept_count_ff <= kept_in;
         mid_last_ff       <= req_data.last_of_record;
      end
   end

   pim_stamp #(
      .TOTAL_TICK_BITS(TW)
   ) u_stamp (
      .total_ticks(mid_total_ff),
      .period_ps  (mid_period_ff),
      .stamp_ps   (stamp)
   );

   always_comb begin
      rsp_data_in.interval_valid  = mid_kept_ff;
      rsp_data_in.merged_interval = mid_merged_ff;
      rsp_data_in.timestamp_ps    = stamp;
      rsp_data_in.outlier_count   = mid_outliers_ff;
      rsp_data_in.saturated_count = mid_sats_ff;
      rsp_data_in.kept_count      = mid_kept_count_ff;
      rsp_data_in.end_of_record   = mid_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && mid_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/pim_checker.sv
// Port-level assertions for the photon interval outlier merger, with bind.
module pim_checker import pim_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input pim_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_outlier_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.interval_valid |-> rsp_data.merged_interval == '0)
      else $error("outlier word carries a merged interval");

   a_kept_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.interval_valid |-> rsp_data.kept_count != '0)
      else $error("kept interval not counted");

   a_stall_needs_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

endmodule

bind photon_interval_outlier_merger pim_checker u_pim_checker (
   .clock    (clock),
   .reset    (reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

FILE: verif/tb_top.sv
// Self-checking bench for the photon interval outlier merger: directed, random and saturating records.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pim_pkg::*;

   localparam int TICK_W = PIM_TOTAL_TICK_BITS;
   localparam logic [3:0][PERIOD_W-1:0] PERIOD_PS =
      {16'd49800, 16'd19920, 16'd10000, 16'd6500};

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_ALTERNATE, STALL_HEAVY} stall_pattern_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   pim_req_type            req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   pim_rsp_type            rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // predictor copy of configuration and record state
   logic [15:0]       cfg_threshold = '0;
   logic [1:0]        cfg_clock_sel = '0;
   logic [31:0]       rec_pending = '0;
   logic [TICK_W-1:0] rec_ticks = '0;
   logic [31:0]       rec_outliers = '0;
   logic [31:0]       rec_saturated = '0;
   logic [31:0]       rec_kept = '0;

   pim_req_type       sample_queue[$];
   pim_rsp_type       due_reports[$];
   int                burst_left = 0;
   int                gap_left = 0;
   stall_pattern_type stall_mode = STALL_NONE;
   int                stall_left = 0;
   int                stall_tick = 0;
   int                mismatch_count = 0;

   photon_interval_outlier_merger uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic pim_rsp_type merge_sample(input pim_req_type w);
      pim_rsp_type     r;
      logic [32:0]     sum;
      logic [TICK_W:0] ticks;
      logic [63:0]     stamp;
      r = '0;
      if (w.first_of_record) begin
         rec_pending   = '0;
         rec_ticks     = '0;
         rec_outliers  = '0;
         rec_saturated = '0;
         rec_kept      = '0;
      end
      if (w.sample_ticks > SAT_LIMIT)
         rec_saturated = rec_saturated + 32'(rec_saturated != 32'hFFFF_FFFF);
      sum = {17'd0, w.sample_ticks} + {1'b0, rec_pending};
      if (w.sample_ticks < cfg_threshold) begin
         rec_outliers = rec_outliers + 32'(rec_outliers != 32'hFFFF_FFFF);
         rec_pending  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end else begin
         r.interval_valid  = 1'b1;
         r.merged_interval = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         rec_pending       = '0;
         ticks     = {1'b0, rec_ticks} + {{(TICK_W-31){1'b0}}, r.merged_interval};
         rec_ticks = ticks[TICK_W] ? {TICK_W{1'b1}} : ticks[TICK_W-1:0];
         rec_kept  = rec_kept + 32'(rec_kept != 32'hFFFF_FFFF);
      end
      if (w.last_of_record)
         rec_pending = '0;
      stamp = 64'(rec_ticks) * 64'(PERIOD_PS[cfg_clock_sel]);
      r.timestamp_ps    = (stamp[63:STAMP_W] != '0) ? {STAMP_W{1'b1}} : stamp[STAMP_W-1:0];
      r.outlier_count   = rec_outliers;
      r.saturated_count = rec_saturated;
      r.kept_count      = rec_kept;
      r.end_of_record   = w.last_of_record;
      return r;
   endfunction

   function automatic string describe_report(input pim_rsp_type r);
      return $sformatf("valid=%0b merged=%0h stamp=%0h outliers=%0d saturated=%0d kept=%0d end=%0b",
                       r.interval_valid, r.merged_interval, r.timestamp_ps, r.outlier_count,
                       r.saturated_count, r.kept_count, r.end_of_record);
   endfunction

   task automatic check_report(input pim_rsp_type got);
      pim_rsp_type want;
      logic        bad;
      if (due_reports.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected word: %s", describe_report(got));
      end else begin
         want = due_reports.pop_front();
         bad  = (got.interval_valid !== want.interval_valid) ||
                (got.merged_interval !== want.merged_interval) ||
                (got.timestamp_ps !== want.timestamp_ps) ||
                (got.outlier_count !== want.outlier_count) ||
                (got.saturated_count !== want.saturated_count) ||
                (got.kept_count !== want.kept_count) ||
                (got.end_of_record !== want.end_of_record);
         if (bad) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("expected %s", describe_report(want));
               $display("actual   %s", describe_report(got));
            end
         end
      end
   endtask

   // driver: bursts of words with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            due_reports.push_back(merge_sample(req_data));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
               req_data  <= sample_queue.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0)
                  burst_left--;
               if (burst_left == 0) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check accepted words, stall on a changing pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_report(rsp_data);
         if (stall_left == 0) begin
            stall_mode = stall_pattern_type'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
         end
         stall_left--;
         stall_tick++;
         case (stall_mode)
            STALL_NONE:      rsp_stall <= 1'b0;
            STALL_RANDOM:    rsp_stall <= ($urandom_range(0, 2) == 0);
            STALL_ALTERNATE: rsp_stall <= (stall_tick % 2 == 1);
            default:         rsp_stall <= (stall_tick % 4 != 0);
         endcase
      end
   end

   function automatic void add_word(input logic [15:0] s, input logic f, input logic l);
      pim_req_type w;
      w.sample_ticks    = s;
      w.first_of_record = f;
      w.last_of_record  = l;
      sample_queue.push_back(w);
   endfunction

   function automatic logic [15:0] pick_sample();
      int v;
      case ($urandom_range(0, 9))
         0:       v = 0;
         1:       v = 65535;
         2:       v = $urandom_range(65532, 65535);
         3, 4:    v = int'(cfg_threshold) + int'($urandom_range(0, 4)) - 2;
         5:       v = (cfg_threshold == 0) ? 0 : $urandom_range(0, cfg_threshold - 1);
         default: v = $urandom_range(0, 65535);
      endcase
      if (v < 0)
         v = 0;
      else if (v > 65535)
         v = 65535;
      return v[15:0];
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || due_reports.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_THRESHOLD)
         cfg_threshold = val;
      else if (idx == CSR_CLOCK_SEL)
         cfg_clock_sel = val[1:0];
   endtask

   task automatic run_records(input int count);
      int made;
      int len;
      made = 0;
      @(negedge clock);
      while (made < count) begin
         if ($urandom_range(0, 6) == 0) begin
            // noise: marks at random
            add_word(pick_sample(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            made++;
         end else begin
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++) begin
               add_word(pick_sample(), i == 0, i == len - 1);
               made++;
            end
         end
      end
      wait_idle();
   endtask

   initial begin
      logic [15:0] thr;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: threshold zero keeps every sample
      @(negedge clock);
      add_word(16'd0, 1'b1, 1'b0);
      add_word(16'hFFFF, 1'b0, 1'b0);
      add_word(16'd65533, 1'b0, 1'b0);
      add_word(16'd65534, 1'b0, 1'b1);
      wait_idle();

      write_reg(CSR_THRESHOLD, 16'd1000);
      write_reg(CSR_CLOCK_SEL, CSR_DATA_W'(CLK_49800PS));
      @(negedge clock);
      add_word(16'd5, 1'b1, 1'b0);
      add_word(16'd999, 1'b0, 1'b0);
      add_word(16'd1000, 1'b0, 1'b0);
      add_word(16'd1001, 1'b0, 1'b0);
      add_word(16'd7, 1'b0, 1'b1);
      add_word(16'd1500, 1'b0, 1'b0);
      add_word(16'd3, 1'b0, 1'b0);
      add_word(16'd2000, 1'b1, 1'b1);
      wait_idle();

      write_reg(CSR_THRESHOLD, 16'hFFFF);
      write_reg(CSR_CLOCK_SEL, CSR_DATA_W'(CLK_19920PS));
      @(negedge clock);
      add_word(16'd65534, 1'b1, 1'b0);
      add_word(16'd0, 1'b0, 1'b0);
      add_word(16'hFFFF, 1'b0, 1'b0);
      add_word(16'hFFFF, 1'b0, 1'b1);
      wait_idle();

      write_reg(CSR_CLOCK_SEL, CSR_DATA_W'(CLK_10000PS));
      @(negedge clock);
      add_word(16'd12345, 1'b1, 1'b0);
      add_word(16'hFFFF, 1'b0, 1'b1);
      wait_idle();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       thr = 16'($urandom_range(1, 64));
            1:       thr = 16'hFFFF;
            2:       thr = 16'd0;
            3:       thr = 16'd1;
            4:       thr = 16'h8000;
            default: thr = 16'($urandom_range(0, 65535));
         endcase
         write_reg(CSR_THRESHOLD, thr);
         write_reg(CSR_CLOCK_SEL, CSR_DATA_W'($urandom_range(0, 3)));
         run_records(115);
      end

      // two runs of large outliers, each merged into the kept interval that follows it
      write_reg(CSR_THRESHOLD, 16'hFFFF);
      write_reg(CSR_CLOCK_SEL, CSR_DATA_W'(CLK_49800PS));
      @(negedge clock);
      add_word(16'hFFFE, 1'b1, 1'b0);
      repeat (6) add_word(16'hFFFE, 1'b0, 1'b0);
      add_word(16'hFFFF, 1'b0, 1'b0);
      add_word(16'hFFFE, 1'b0, 1'b0);
      add_word(16'hFFFF, 1'b0, 1'b1);
      wait_idle();

      repeat (8) @(posedge clock);
      if (due_reports.size() != 0)
         $display("words never returned: %0d", due_reports.size());
      if (mismatch_count == 0 && due_reports.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #6_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
